// ===== src/ws_drv_pkg.sv =====
package ws_drv_pkg;

    // Request codes carried in req_type
    localparam logic [2:0] REQ_SET_PIX  = 3'd0;
    localparam logic [2:0] REQ_SET_ALL  = 3'd1;
    localparam logic [2:0] REQ_CLEAR    = 3'd2;
    localparam logic [2:0] REQ_REFRESH  = 3'd3;
    localparam logic [2:0] REQ_TICK     = 3'd4;

    // Configuration register indexes
    localparam logic [2:0] CFG_ZERO_HIGH = 3'd0;
    localparam logic [2:0] CFG_ZERO_LOW  = 3'd1;
    localparam logic [2:0] CFG_ONE_HIGH  = 3'd2;
    localparam logic [2:0] CFG_ONE_LOW   = 3'd3;
    localparam logic [2:0] CFG_LATCH_LOW = 3'd4;
    localparam logic [2:0] CFG_LED_COUNT = 3'd5;

    localparam int CFG_DW = 15;

    // Reset values of the timing and chain length registers
    localparam logic [7:0]  RST_ZERO_HIGH = 8'd16;
    localparam logic [7:0]  RST_ZERO_LOW  = 8'd48;
    localparam logic [7:0]  RST_ONE_HIGH  = 8'd48;
    localparam logic [7:0]  RST_ONE_LOW   = 8'd16;
    localparam logic [14:0] RST_LATCH_LOW = 15'd20000;
    localparam logic [6:0]  RST_LED_COUNT = 7'd49;

    // Command queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic [2:0] req_type;
        logic [5:0] pixel_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_in_item;

    typedef struct packed {
        logic line_level;
        logic busy_res;
        logic frame_done;
    } t_out_item;

    typedef enum logic [2:0] {
        OP_SET_PIX,
        OP_SET_ALL,
        OP_CLEAR,
        OP_REFRESH,
        OP_TICK,
        OP_NOP
    } t_op;

    // Classified command; color already in wire order (G, R, B)
    typedef struct packed {
        t_op        op;
        logic [5:0] idx;
        logic [23:0] grb;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef struct packed {
        logic [7:0]  zero_high;
        logic [7:0]  zero_low;
        logic [7:0]  one_high;
        logic [7:0]  one_low;
        logic [14:0] latch_low;
        logic [6:0]  led_count;
    } t_timing;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HIGH,
        PH_LOW,
        PH_LATCH
    } t_phase;

endpackage

// ===== src/ws_drv_front.sv =====
module ws_drv_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  ws_drv_pkg::t_in_item i_in_data,
    input  ws_drv_pkg::t_q_stat i_q_stat,
    output logic                o_push,
    output ws_drv_pkg::t_cmd    o_cmd
);
    import ws_drv_pkg::*;

    logic r_valid;
    t_cmd r_cmd;
    t_cmd n_cmd;

    always_comb begin
        n_cmd.idx = i_in_data.pixel_index;
        n_cmd.grb = {i_in_data.green, i_in_data.red, i_in_data.blue};
        unique case (i_in_data.req_type)
            REQ_SET_PIX: n_cmd.op = OP_SET_PIX;
            REQ_SET_ALL: n_cmd.op = OP_SET_ALL;
            REQ_CLEAR:   n_cmd.op = OP_CLEAR;
            REQ_REFRESH: n_cmd.op = OP_REFRESH;
            REQ_TICK:    n_cmd.op = OP_TICK;
            default:     n_cmd.op = OP_NOP;
        endcase
    end

    assign o_in_stall = r_valid && i_q_stat.full;
    assign o_push     = r_valid && !i_q_stat.full;
    assign o_cmd      = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

// ===== src/ws_drv_fifo.sv =====
module ws_drv_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  ws_drv_pkg::t_cmd    i_cmd,
    input  logic                i_pop,
    output ws_drv_pkg::t_cmd    o_cmd,
    output ws_drv_pkg::t_q_stat o_stat
);
    import ws_drv_pkg::*;

    t_cmd            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr_ptr;
    logic [Q_AW-1:0] r_rd_ptr;
    logic [Q_CW-1:0] r_count;

    assign o_stat.full  = (r_count == Q_CW'(Q_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_cmd        = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + Q_AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + Q_AW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + Q_CW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - Q_CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// ===== src/ws_drv_back.sv =====
module ws_drv_back #(
    parameter int MAX_LEDS = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ws_drv_pkg::t_timing   i_cfg,
    input  ws_drv_pkg::t_cmd      i_cmd,
    input  ws_drv_pkg::t_q_stat   i_q_stat,
    output logic                  o_pop,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output ws_drv_pkg::t_out_item o_out_data
);
    import ws_drv_pkg::*;

    localparam int AW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
    localparam int CW = $clog2(MAX_LEDS + 1);

    function automatic logic [14:0] f_min1(input logic [14:0] v);
        return (v == '0) ? 15'd1 : v;
    endfunction

    // Pixel store: GRB words, valid bit per entry, fill value for unwritten ones
    logic [23:0]         r_mem [MAX_LEDS];
    logic [MAX_LEDS-1:0] r_vbits;
    logic [23:0]         r_fill;
    logic [23:0]         r_rd_data;
    logic                r_rd_ok;
    logic                r_pend;

    // Sequencer state
    t_phase      r_phase, n_phase;
    logic [AW-1:0] r_pos, n_pos;
    logic [4:0]  r_bit, n_bit;
    logic [23:0] r_word, n_word;
    logic [23:0] r_next_word, n_next_word;
    logic [14:0] r_ticks, n_ticks;
    logic        done;

    logic          r_out_valid;
    t_out_item     r_out, n_res;

    logic [CW-1:0] eff_cnt;
    logic [23:0]   nw_cur;
    logic          idle;
    logic          last_led;
    logic          wr_en, rd_en, set_all;
    logic [AW-1:0] wr_addr, rd_addr, addr_one, addr_after;
    logic [23:0]   fill_val;

    assign o_pop = !i_q_stat.empty && (!r_out_valid || !i_out_stall);
    assign idle  = (r_phase == PH_IDLE);

    always_comb begin
        if (i_cfg.led_count == '0) begin
            eff_cnt = CW'(1);
        end else if (32'(i_cfg.led_count) > 32'(MAX_LEDS)) begin
            eff_cnt = CW'(MAX_LEDS);
        end else begin
            eff_cnt = CW'(i_cfg.led_count);
        end
    end

    // Word of the next LED, taking a just-returned store read into account
    assign nw_cur     = r_pend ? (r_rd_ok ? r_rd_data : r_fill) : r_next_word;
    assign last_led   = (32'(r_pos) + 32'd1) >= 32'(eff_cnt);
    assign addr_one   = (MAX_LEDS > 1) ? AW'(1) : '0;
    assign addr_after = ((32'(r_pos) + 32'd2) >= 32'(MAX_LEDS)) ? '0
                                                                : AW'(32'(r_pos) + 32'd2);
    assign wr_addr    = AW'(i_cmd.idx);

    // Next state
    always_comb begin
        n_phase     = r_phase;
        n_pos       = r_pos;
        n_bit       = r_bit;
        n_word      = r_word;
        n_ticks     = r_ticks;
        n_next_word = nw_cur;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = '0;
        set_all     = 1'b0;
        fill_val    = '0;
        done        = 1'b0;
        if (o_pop) begin
            unique case (i_cmd.op)
                OP_SET_PIX: begin
                    if (idle && (32'(i_cmd.idx) < 32'(eff_cnt))) begin
                        wr_en = 1'b1;
                        if (i_cmd.idx == '0) begin
                            n_next_word = i_cmd.grb;
                        end
                    end
                end
                OP_SET_ALL: begin
                    if (idle) begin
                        set_all     = 1'b1;
                        fill_val    = i_cmd.grb;
                        n_next_word = i_cmd.grb;
                    end
                end
                OP_CLEAR: begin
                    if (idle) begin
                        set_all     = 1'b1;
                        n_next_word = '0;
                        n_pos       = '0;
                        n_bit       = '0;
                        n_word      = '0;
                        n_phase     = PH_HIGH;
                        n_ticks     = f_min1(15'(i_cfg.zero_high));
                    end
                end
                OP_REFRESH: begin
                    if (idle) begin
                        rd_en   = 1'b1;
                        rd_addr = addr_one;
                        n_pos   = '0;
                        n_bit   = '0;
                        n_word  = nw_cur;
                        n_phase = PH_HIGH;
                        n_ticks = f_min1(15'(nw_cur[23] ? i_cfg.one_high
                                                        : i_cfg.zero_high));
                    end
                end
                OP_TICK: begin
                    if (!idle && (r_ticks > 15'd1)) begin
                        n_ticks = r_ticks - 15'd1;
                    end else begin
                        unique case (r_phase)
                            PH_IDLE: begin
                            end
                            PH_HIGH: begin
                                n_phase = PH_LOW;
                                n_ticks = f_min1(15'(r_word[23] ? i_cfg.one_low
                                                                : i_cfg.zero_low));
                            end
                            PH_LOW: begin
                                if (r_bit == 5'd23) begin
                                    if (last_led) begin
                                        n_phase = PH_LATCH;
                                        n_ticks = f_min1(i_cfg.latch_low);
                                        rd_en   = 1'b1;
                                        rd_addr = '0;
                                    end else begin
                                        n_pos   = r_pos + AW'(1);
                                        n_bit   = '0;
                                        n_word  = nw_cur;
                                        n_phase = PH_HIGH;
                                        n_ticks = f_min1(15'(nw_cur[23] ? i_cfg.one_high
                                                                        : i_cfg.zero_high));
                                        rd_en   = 1'b1;
                                        rd_addr = addr_after;
                                    end
                                end else begin
                                    n_bit   = r_bit + 5'd1;
                                    n_word  = {r_word[22:0], 1'b0};
                                    n_phase = PH_HIGH;
                                    n_ticks = f_min1(15'(r_word[22] ? i_cfg.one_high
                                                                    : i_cfg.zero_high));
                                end
                            end
                            PH_LATCH: begin
                                n_phase = PH_IDLE;
                                n_ticks = '0;
                                done    = 1'b1;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                OP_NOP: begin
                end
                default: begin
                end
            endcase
        end
    end

    // Result of the item being executed
    always_comb begin
        n_res.line_level = (n_phase == PH_HIGH);
        n_res.busy_res   = (n_phase != PH_IDLE);
        n_res.frame_done = done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_pos       <= '0;
            r_bit       <= '0;
            r_word      <= '0;
            r_next_word <= '0;
            r_ticks     <= '0;
            r_pend      <= 1'b0;
            r_vbits     <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_pos       <= n_pos;
            r_bit       <= n_bit;
            r_word      <= n_word;
            r_next_word <= n_next_word;
            r_ticks     <= n_ticks;
            r_pend      <= rd_en;
            if (set_all) begin
                r_vbits <= '0;
                r_fill  <= fill_val;
            end else if (wr_en) begin
                r_vbits[wr_addr] <= 1'b1;
            end
            if (o_pop) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= i_cmd.grb;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
            r_rd_ok   <= r_vbits[rd_addr];
        end
        if (o_pop) begin
            r_out <= n_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== src/ws2812_led_chain_driver_unit.sv =====
// LED chain driver: pixel store plus serial line sequencer, one tick per item.
// Path: an accepted item passes the front register, then the queue, then execution
//   into the output register.
// Throughput: one item per cycle while the queue is not full and the output is not stalled.
// Reset: synchronous, active low; the pixel store reads as black at once through
//   per-entry valid bits, so no clearing pass and no dead time after reset.
module ws2812_led_chain_driver_unit #(
    parameter int MAX_LEDS = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // item input
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  ws_drv_pkg::t_in_item  i_in_data,
    // result output
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output ws_drv_pkg::t_out_item o_out_data,
    // register writes
    input  logic                  i_cfg_we,
    input  logic [2:0]            i_cfg_index,
    input  logic [14:0]           i_cfg_data
);
    import ws_drv_pkg::*;

    // Timing and chain length registers
    t_timing r_cfg;

    // Front -> queue -> back
    logic    q_push;
    logic    q_pop;
    t_cmd    f_cmd;
    t_cmd    q_cmd;
    t_q_stat q_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.zero_high <= RST_ZERO_HIGH;
            r_cfg.zero_low  <= RST_ZERO_LOW;
            r_cfg.one_high  <= RST_ONE_HIGH;
            r_cfg.one_low   <= RST_ONE_LOW;
            r_cfg.latch_low <= RST_LATCH_LOW;
            r_cfg.led_count <= RST_LED_COUNT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ZERO_HIGH: r_cfg.zero_high <= i_cfg_data[7:0];
                CFG_ZERO_LOW:  r_cfg.zero_low  <= i_cfg_data[7:0];
                CFG_ONE_HIGH:  r_cfg.one_high  <= i_cfg_data[7:0];
                CFG_ONE_LOW:   r_cfg.one_low   <= i_cfg_data[7:0];
                CFG_LATCH_LOW: r_cfg.latch_low <= i_cfg_data[CFG_DW-1:0];
                CFG_LED_COUNT: r_cfg.led_count <= i_cfg_data[6:0];
                default: begin
                    // unused index: write dropped
                end
            endcase
        end
    end

    // Front: registers and classifies each item
    ws_drv_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .i_q_stat   (q_stat),
        .o_push     (q_push),
        .o_cmd      (f_cmd)
    );

    // Short command queue so front and back stall independently
    ws_drv_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (f_cmd),
        .i_pop   (q_pop),
        .o_cmd   (q_cmd),
        .o_stat  (q_stat)
    );

    // Back: pixel store, bit/phase sequencer, output register
    ws_drv_back #(
        .MAX_LEDS (MAX_LEDS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd       (q_cmd),
        .i_q_stat    (q_stat),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // Frame end always returns to idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.frame_done |-> !o_out_data.busy_res)
        else $error("frame_done while still busy");

    // Line only driven high inside a frame
    a_line_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.line_level |-> o_out_data.busy_res)
        else $error("line high while idle");

    // Back never pops an empty queue
    a_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_stat.empty)
        else $error("pop from empty queue");

    // Queue never pushed while full
    a_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_stat.full)
        else $error("push into full queue");

endmodule
